// ===== hw/rtl/v3n_pkg.sv =====
package v3n_pkg;

   localparam int unsigned CompW     = 32;  // width of an input component port
   localparam int unsigned MagW      = 32;  // absolute value, up to 2^31
   localparam int unsigned SumW      = 64;  // exact sum of three squares
   localparam int unsigned LenW      = 32;  // floor of the square root
   localparam int unsigned QuoW      = 31;  // quotient bits 30..0 of Q1.30
   localparam int unsigned RemW      = 33;  // divider partial remainder
   localparam int unsigned OutW      = 32;  // normalised component width
   localparam int unsigned Lanes     = 3;
   localparam int unsigned SqrtSteps = LenW;
   localparam int unsigned DivSteps  = QuoW;
   localparam int unsigned MinCompW  = 16;

   typedef logic [CompW-1:0] comp_type;

   typedef struct packed {
      logic [Lanes-1:0][MagW-1:0] mag;
      logic [Lanes-1:0]           neg;
   } mag_stage_type;

   typedef struct packed {
      logic [Lanes-1:0][MagW-1:0] mag;
      logic [Lanes-1:0]           neg;
      logic [Lanes-1:0][SumW-1:0] sq;
   } sqr_stage_type;

   typedef struct packed {
      logic [Lanes-1:0][MagW-1:0] mag;
      logic [Lanes-1:0]           neg;
      logic [SumW-1:0]            rem;
      logic [LenW-1:0]            root;
   } root_stage_type;

   typedef struct packed {
      logic [LenW-1:0]            len;
      logic [Lanes-1:0][RemW-1:0] rem;
      logic [Lanes-1:0][QuoW-1:0] quo;
      logic [Lanes-1:0]           neg;
   } div_stage_type;

endpackage

// ===== hw/rtl/v3n_if.sv =====
interface v3n_req_if;
   logic                valid;
   logic                ready;
   v3n_pkg::comp_type   x_in;
   v3n_pkg::comp_type   y_in;
   v3n_pkg::comp_type   z_in;

   modport source (output valid, output x_in, output y_in, output z_in, input ready);
   modport sink (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface v3n_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [v3n_pkg::OutW-1:0]    nx;
   logic [v3n_pkg::OutW-1:0]    ny;
   logic [v3n_pkg::OutW-1:0]    nz;
   logic [v3n_pkg::LenW-1:0]    length;
   logic                        is_zero;

   modport source (output valid, output nx, output ny, output nz, output length,
                   output is_zero, input ready);
   modport sink (input valid, input nx, input ny, input nz, input length,
                 input is_zero, output ready);
endinterface

// ===== hw/rtl/v3n_prep.sv =====
module v3n_prep #(
   parameter int unsigned CW_EFF = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  v3n_pkg::comp_type        x_in,
   input  v3n_pkg::comp_type        y_in,
   input  v3n_pkg::comp_type        z_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output v3n_pkg::root_stage_type  out_data
);

   localparam logic [v3n_pkg::CompW:0] Span = (v3n_pkg::CompW+1)'(1) << CW_EFF;
   localparam logic [v3n_pkg::CompW:0] Mask = Span - (v3n_pkg::CompW+1)'(1);

   logic                      v0_ff, v1_ff, v2_ff;
   logic                      rdy0, rdy1, rdy2;
   v3n_pkg::mag_stage_type    s0_ff, s0_in;
   v3n_pkg::sqr_stage_type    s1_ff, s1_in;
   v3n_pkg::root_stage_type   s2_ff, s2_in;
   v3n_pkg::comp_type         raw [v3n_pkg::Lanes];
   logic [v3n_pkg::CompW:0]   vext [v3n_pkg::Lanes];

   assign raw[0] = x_in;
   assign raw[1] = y_in;
   assign raw[2] = z_in;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   // take the component apart into absolute value and sign
   always_comb begin
      for (int l = 0; l < v3n_pkg::Lanes; l++) begin
         vext[l] = {1'b0, raw[l]} & Mask;
         s0_in.neg[l] = vext[l][CW_EFF-1];
         s0_in.mag[l] = s0_in.neg[l] ? v3n_pkg::MagW'(Span - vext[l])
                                     : v3n_pkg::MagW'(vext[l]);
      end
   end

   always_comb begin
      s1_in.mag = s0_ff.mag;
      s1_in.neg = s0_ff.neg;
      for (int l = 0; l < v3n_pkg::Lanes; l++) begin
         s1_in.sq[l] = v3n_pkg::SumW'(s0_ff.mag[l]) * v3n_pkg::SumW'(s0_ff.mag[l]);
      end
   end

   always_comb begin
      s2_in.mag  = s1_ff.mag;
      s2_in.neg  = s1_ff.neg;
      s2_in.rem  = s1_ff.sq[0] + s1_ff.sq[1] + s1_ff.sq[2];
      s2_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0 && in_valid) s0_ff <= s0_in;
      if (rdy1 && v0_ff)    s1_ff <= s1_in;
      if (rdy2 && v1_ff)    s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

// ===== hw/rtl/v3n_sqrt_cell.sv =====
module v3n_sqrt_cell #(
   parameter int unsigned BIT = 31
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  v3n_pkg::root_stage_type  in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output v3n_pkg::root_stage_type  out_data
);

   localparam int unsigned TrialW = v3n_pkg::SumW + 2;

   logic                      valid_ff;
   v3n_pkg::root_stage_type   data_ff, data_in;
   logic [TrialW-1:0]         trial;

   assign in_ready = !valid_ff || out_ready;

   // try setting this root bit: (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
   always_comb begin
      trial   = (TrialW'(in_data.root) << (BIT + 1)) + (TrialW'(1) << (2 * BIT));
      data_in = in_data;
      if ({2'b00, in_data.rem} >= trial) begin
         data_in.rem  = in_data.rem - trial[v3n_pkg::SumW-1:0];
         data_in.root = in_data.root | (v3n_pkg::LenW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/v3n_div_cell.sv =====
module v3n_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  v3n_pkg::div_stage_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output v3n_pkg::div_stage_type  out_data
);

   logic                     valid_ff;
   v3n_pkg::div_stage_type   data_ff, data_in;
   logic [v3n_pkg::RemW-1:0] diff [v3n_pkg::Lanes];
   logic [v3n_pkg::RemW-1:0] lenx;
   logic                     take [v3n_pkg::Lanes];

   assign in_ready = !valid_ff || out_ready;
   assign lenx     = v3n_pkg::RemW'(in_data.len);

   // one quotient bit per lane, then shift the remainder up
   always_comb begin
      data_in = in_data;
      for (int l = 0; l < v3n_pkg::Lanes; l++) begin
         take[l] = in_data.rem[l] >= lenx;
         diff[l] = take[l] ? (in_data.rem[l] - lenx) : in_data.rem[l];
         data_in.rem[l] = diff[l] << 1;
         data_in.quo[l] = {in_data.quo[l][v3n_pkg::QuoW-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/v3n_pack.sv =====
module v3n_pack (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  v3n_pkg::div_stage_type  in_data,
   v3n_rsp_if.source               rsp
);

   logic                           valid_ff;
   logic [v3n_pkg::OutW-1:0]       comp_ff [v3n_pkg::Lanes];
   logic [v3n_pkg::OutW-1:0]       comp_in [v3n_pkg::Lanes];
   logic [v3n_pkg::LenW-1:0]       len_ff;
   logic                           zero_ff, zero_in;
   logic [v3n_pkg::OutW-1:0]       q [v3n_pkg::Lanes];

   assign in_ready = !valid_ff || rsp.ready;
   assign zero_in  = in_data.len == '0;

   // restore the sign; a zero vector forces zero components
   always_comb begin
      for (int l = 0; l < v3n_pkg::Lanes; l++) begin
         q[l] = v3n_pkg::OutW'(in_data.quo[l]);
         if (zero_in) begin
            comp_in[l] = '0;
         end else if (in_data.neg[l]) begin
            comp_in[l] = -q[l];
         end else begin
            comp_in[l] = q[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         comp_ff <= comp_in;
         len_ff  <= in_data.len;
         zero_ff <= zero_in;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.nx      = comp_ff[0];
   assign rsp.ny      = comp_ff[1];
   assign rsp.nz      = comp_ff[2];
   assign rsp.length  = len_ff;
   assign rsp.is_zero = zero_ff;

endmodule

// ===== hw/rtl/vector3_normalize_top.sv =====
// Pipeline of 3 prep stages, 32 square-root cells, 31 divider cells, 1 output register.
// Throughput: one vector per cycle when the result side does not stall; every cell is
// a register with its own valid bit, so bubbles close up and input is taken while a
// finished result waits, as long as a cell is free.
// Reset (synchronous, active high) clears all valid bits; no payload is cleared.
module vector3_normalize_top #(
   parameter int unsigned COMPONENT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   v3n_req_if.sink     req,
   v3n_rsp_if.source   rsp
);

   localparam int unsigned CwEff =
      (COMPONENT_WIDTH < v3n_pkg::MinCompW) ? v3n_pkg::MinCompW :
      ((COMPONENT_WIDTH > v3n_pkg::CompW) ? v3n_pkg::CompW : COMPONENT_WIDTH);

   logic                     sq_valid [v3n_pkg::SqrtSteps+1];
   logic                     sq_ready [v3n_pkg::SqrtSteps+1];
   v3n_pkg::root_stage_type  sq_data  [v3n_pkg::SqrtSteps+1];

   logic                     dv_valid [v3n_pkg::DivSteps+1];
   logic                     dv_ready [v3n_pkg::DivSteps+1];
   v3n_pkg::div_stage_type   dv_data  [v3n_pkg::DivSteps+1];

   v3n_prep #(
      .CW_EFF (CwEff)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .x_in      (req.x_in),
      .y_in      (req.y_in),
      .z_in      (req.z_in),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_data  (sq_data[0])
   );

   // root bits from the top down
   for (genvar i = 0; i < v3n_pkg::SqrtSteps; i++) begin : g_sqrt
      v3n_sqrt_cell #(
         .BIT (v3n_pkg::SqrtSteps - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[i]),
         .in_ready  (sq_ready[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_valid[i+1]),
         .out_ready (sq_ready[i+1]),
         .out_data  (sq_data[i+1])
      );
   end

   assign dv_valid[0] = sq_valid[v3n_pkg::SqrtSteps];
   assign sq_ready[v3n_pkg::SqrtSteps] = dv_ready[0];

   always_comb begin
      dv_data[0].len = sq_data[v3n_pkg::SqrtSteps].root;
      dv_data[0].neg = sq_data[v3n_pkg::SqrtSteps].neg;
      dv_data[0].quo = '0;
      for (int l = 0; l < v3n_pkg::Lanes; l++) begin
         dv_data[0].rem[l] = v3n_pkg::RemW'(sq_data[v3n_pkg::SqrtSteps].mag[l]);
      end
   end

   for (genvar i = 0; i < v3n_pkg::DivSteps; i++) begin : g_div
      v3n_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[i]),
         .in_ready  (dv_ready[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i+1]),
         .out_ready (dv_ready[i+1]),
         .out_data  (dv_data[i+1])
      );
   end

   v3n_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dv_valid[v3n_pkg::DivSteps]),
      .in_ready (dv_ready[v3n_pkg::DivSteps]),
      .in_data  (dv_data[v3n_pkg::DivSteps]),
      .rsp      (rsp)
   );

endmodule

// ===== tb/v3n_checker.sv =====
module v3n_checker (
   input  logic      clock,
   input  logic      reset,
   v3n_req_if.sink   req_mon,
   v3n_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [v3n_pkg::OutW-1:0] nx;
      logic [v3n_pkg::OutW-1:0] ny;
      logic [v3n_pkg::OutW-1:0] nz;
      logic [v3n_pkg::LenW-1:0] length;
      logic                     is_zero;
   } unit_vec_type;

   unit_vec_type unit_queue[$];

   function automatic logic [63:0] abs_comp(logic [31:0] raw, output logic neg);
      neg = raw[31];
      return neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] rem, root, b;
      rem  = v;
      root = 0;
      b    = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem  = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] scale_comp(logic [63:0] m, logic neg, logic [63:0] len);
      logic [63:0] q;
      q = (m << 30) / len;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      if (neg) q = 64'd0 - q;
      return q[31:0];
   endfunction

   function automatic unit_vec_type normalise(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z);
      unit_vec_type r;
      logic         sx, sy, sz;
      logic [63:0]  mx, my, mz, len;
      mx  = abs_comp(x, sx);
      my  = abs_comp(y, sy);
      mz  = abs_comp(z, sz);
      len = floor_root(mx * mx + my * my + mz * mz);
      if (len == 0) begin
         r = '{0, 0, 0, 0, 1'b1};
      end else begin
         r.nx      = scale_comp(mx, sx, len);
         r.ny      = scale_comp(my, sy, len);
         r.nz      = scale_comp(mz, sz, len);
         r.length  = len[31:0];
         r.is_zero = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      unit_vec_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            unit_queue.push_back(normalise(req_mon.x_in, req_mon.y_in, req_mon.z_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (unit_queue.size() == 0) begin
               $error("unexpected result transfer");
               fail_count <= fail_count + 1;
            end else begin
               e = unit_queue.pop_front();
               if (rsp_mon.nx !== e.nx || rsp_mon.ny !== e.ny || rsp_mon.nz !== e.nz ||
                   rsp_mon.length !== e.length || rsp_mon.is_zero !== e.is_zero)
                  fail_count <= fail_count + 1;
               if (rsp_mon.nx !== e.nx)
                  $error("nx expected %h actual %h", e.nx, rsp_mon.nx);
               if (rsp_mon.ny !== e.ny)
                  $error("ny expected %h actual %h", e.ny, rsp_mon.ny);
               if (rsp_mon.nz !== e.nz)
                  $error("nz expected %h actual %h", e.nz, rsp_mon.nz);
               if (rsp_mon.length !== e.length)
                  $error("length expected %h actual %h", e.length, rsp_mon.length);
               if (rsp_mon.is_zero !== e.is_zero)
                  $error("is_zero expected %b actual %b", e.is_zero, rsp_mon.is_zero);
            end
         end
      end
      pending <= unit_queue.size();
   end
endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   bit   long_hold = 1'b0;
   bit   stim_done = 1'b0;

   v3n_req_if req_if ();
   v3n_rsp_if rsp_if ();

   vector3_normalize_top dut (.clock(clock), .reset(reset), .req(req_if.sink),
                              .rsp(rsp_if.source));

   v3n_checker checker_inst (.clock(clock), .reset(reset), .req_mon(req_if.sink),
                             .rsp_mon(rsp_if.sink), .fail_count(fail_count),
                             .pending(pending));

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.x_in  = '0;
      req_if.y_in  = '0;
      req_if.z_in  = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(0, 255) - 128;
         4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Hold valid across back-to-back transfers; lower it only for a gap.
   task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.x_in  <= x;
      req_if.y_in  <= y;
      req_if.z_in  <= z;
      do @(posedge clock); while (!req_if.ready);
   endtask

   initial begin
      logic [31:0] edge_vals[6];
      edge_vals = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_vec(0, 0, 0);
      foreach (edge_vals[i]) begin
         send_vec(edge_vals[i], 0, 0);
         send_vec(0, edge_vals[i], 0);
         send_vec(0, 0, edge_vals[i]);
      end
      send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vec(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
      for (int n = 0; n < 500; n++) begin
         if (n == 200) long_hold = 1'b1;
         send_vec(rand_comp(), rand_comp(), rand_comp());
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      wait (stim_done);
      // let the checker count the last transfer first
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
